@@ src/lbb_pkg.sv @@
package lbb_pkg;

  // Field widths
  localparam int unsigned TIME_W     = 32;
  localparam int unsigned PERIOD_W   = 16;
  localparam int unsigned LEVEL_W    = 8;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 16;

  // Default depth of the raised-cosine curve
  localparam int unsigned CURVE_ENTRIES_DEF = 256;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_BREATH_MIN  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BREATH_MAX  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ALARM_LEVEL = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_BLINK_HALF  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_RUN_PERIOD  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_IDLE_PERIOD = 3'd5;

  // Register reset values
  localparam logic [LEVEL_W-1:0]  RST_BREATH_MIN  = 8'd15;
  localparam logic [LEVEL_W-1:0]  RST_BREATH_MAX  = 8'd200;
  localparam logic [LEVEL_W-1:0]  RST_ALARM_LEVEL = 8'd200;
  localparam logic [PERIOD_W-1:0] RST_BLINK_HALF  = 16'd400;
  localparam logic [PERIOD_W-1:0] RST_RUN_PERIOD  = 16'd2000;
  localparam logic [PERIOD_W-1:0] RST_IDLE_PERIOD = 16'd3000;

  // Colours
  localparam logic [LEVEL_W-1:0] COL_ALARM_R = 8'd255;
  localparam logic [LEVEL_W-1:0] COL_ALARM_G = 8'd0;
  localparam logic [LEVEL_W-1:0] COL_ALARM_B = 8'd0;
  localparam logic [LEVEL_W-1:0] COL_RUN_R   = 8'd0;
  localparam logic [LEVEL_W-1:0] COL_RUN_G   = 8'd220;
  localparam logic [LEVEL_W-1:0] COL_RUN_B   = 8'd60;
  localparam logic [LEVEL_W-1:0] COL_IDLE_R  = 8'd255;
  localparam logic [LEVEL_W-1:0] COL_IDLE_G  = 8'd110;
  localparam logic [LEVEL_W-1:0] COL_IDLE_B  = 8'd20;

  // Mode flags that travel with each beat
  typedef struct packed {
    logic dim;
    logic alarm;
    logic running;
  } lbb_mode_t;

endpackage

@@ src/lbb_div_step.sv @@
module lbb_div_step import lbb_pkg::*; (
  input  logic [PERIOD_W-1:0] rem_i,
  input  logic                bit_i,
  input  logic [PERIOD_W-1:0] div_i,
  output logic [PERIOD_W-1:0] rem_o,
  output logic                q_o
);

  logic [PERIOD_W:0] trial;
  logic [PERIOD_W:0] diff;

  // Shift in the next dividend bit and subtract where the divisor fits
  assign trial = {rem_i, bit_i};
  assign diff  = trial - {1'b0, div_i};
  assign q_o   = (trial >= {1'b0, div_i});
  assign rem_o = q_o ? diff[PERIOD_W-1:0] : trial[PERIOD_W-1:0];

endmodule

@@ src/lbb_curve.sv @@
module lbb_curve import lbb_pkg::*; #(
  parameter int unsigned CurveEntries = CURVE_ENTRIES_DEF
) (
  input  logic                            clk_i,
  input  logic [$clog2(CurveEntries)-1:0] addr_i,
  output logic [LEVEL_W-1:0]              data_o
);

  localparam logic [63:0] PiQ30   = 64'd3373259426;
  localparam int unsigned Q30Sh   = 30;
  localparam int unsigned TaylorN = 12;

  // Entry i: round(256 * sin^2(pi*i/CurveEntries)) with sin by Taylor series in Q30
  function automatic logic [LEVEL_W-1:0] curve_entry(input int unsigned i);
    logic [63:0] n;
    logic [63:0] j;
    logic [63:0] y;
    logic [63:0] term;
    logic [63:0] pos;
    logic [63:0] neg;
    logic [63:0] s;
    logic [63:0] t;
    int unsigned k;
    n = 64'(CurveEntries);
    j = (64'(2 * i) <= n) ? 64'(i) : (n - 64'(i));
    y = (PiQ30 * j) / CurveEntries;
    term = y;
    pos  = 64'd0;
    neg  = 64'd0;
    for (k = 0; k < TaylorN; k++) begin
      if ((k % 2) == 0) begin
        pos = pos + term;
      end else begin
        neg = neg + term;
      end
      term = (term * y) >> Q30Sh;
      term = (term * y) >> Q30Sh;
      case (k)
        0:       term = term / 64'd6;
        1:       term = term / 64'd20;
        2:       term = term / 64'd42;
        3:       term = term / 64'd72;
        4:       term = term / 64'd110;
        5:       term = term / 64'd156;
        6:       term = term / 64'd210;
        7:       term = term / 64'd272;
        8:       term = term / 64'd342;
        9:       term = term / 64'd420;
        10:      term = term / 64'd506;
        default: term = term / 64'd600;
      endcase
    end
    s = (pos > neg) ? (pos - neg) : 64'd0;
    if (s > (64'd1 << Q30Sh)) begin
      s = 64'd1 << Q30Sh;
    end
    t = (s * s + (64'd1 << 51)) >> 52;
    return (t > 64'd255) ? 8'hFF : t[LEVEL_W-1:0];
  endfunction

  logic [LEVEL_W-1:0] rom [CurveEntries];
  logic [LEVEL_W-1:0] data_q;

  // Fill the constant table
  for (genvar gi = 0; gi < CurveEntries; gi++) begin : g_rom
    localparam logic [LEVEL_W-1:0] Val = curve_entry(gi);
    assign rom[gi] = Val;
  end

  // Registered read
  always_ff @(posedge clk_i) begin
    data_q <= rom[addr_i];
  end

  assign data_o = data_q;

endmodule

@@ src/led_breathing_blink_brightness.sv @@
// Throughput: one item per cycle; busy stays low, set by the one-bit-per-stage dividers.
// Results are strobed for one cycle and the receiver cannot stall.
// Reset (rst_ni low, asynchronous) empties the pipeline and loads the default registers.
module led_breathing_blink_brightness import lbb_pkg::*; #(
  parameter int unsigned CurveEntries = CURVE_ENTRIES_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start,
  output logic                  busy,
  input  logic [TIME_W-1:0]     now_ms_i,
  input  logic                  dim_i,
  input  logic                  alarm_i,
  input  logic                  running_i,
  output logic                  out_valid_o,
  output logic [LEVEL_W-1:0]    level_o,
  output logic [LEVEL_W-1:0]    red_o,
  output logic [LEVEL_W-1:0]    green_o,
  output logic [LEVEL_W-1:0]    blue_o,
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

  localparam int unsigned IdxW = $clog2(CurveEntries);
  localparam int unsigned XW   = PERIOD_W + IdxW;

  // Configuration registers
  logic [LEVEL_W-1:0]  breath_min_q;
  logic [LEVEL_W-1:0]  breath_max_q;
  logic [LEVEL_W-1:0]  alarm_level_q;
  logic [PERIOD_W-1:0] blink_half_q;
  logic [PERIOD_W-1:0] run_period_q;
  logic [PERIOD_W-1:0] idle_period_q;

  assign cfg_ready_o = 1'b1;
  assign busy        = 1'b0;

  // Take configuration beats
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      breath_min_q  <= RST_BREATH_MIN;
      breath_max_q  <= RST_BREATH_MAX;
      alarm_level_q <= RST_ALARM_LEVEL;
      blink_half_q  <= RST_BLINK_HALF;
      run_period_q  <= RST_RUN_PERIOD;
      idle_period_q <= RST_IDLE_PERIOD;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        REG_BREATH_MIN:  breath_min_q  <= cfg_data_i[LEVEL_W-1:0];
        REG_BREATH_MAX:  breath_max_q  <= cfg_data_i[LEVEL_W-1:0];
        REG_ALARM_LEVEL: alarm_level_q <= cfg_data_i[LEVEL_W-1:0];
        REG_BLINK_HALF:  blink_half_q  <= cfg_data_i;
        REG_RUN_PERIOD:  run_period_q  <= cfg_data_i;
        REG_IDLE_PERIOD: idle_period_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Pick the divisor for this beat, zero counts as one
  logic                in_acc;
  logic [PERIOD_W-1:0] div_sel;
  logic [PERIOD_W-1:0] div_in;

  assign in_acc  = start && !busy;
  assign div_sel = alarm_i ? blink_half_q : (running_i ? run_period_q : idle_period_q);
  assign div_in  = (div_sel == '0) ? PERIOD_W'(1) : div_sel;

  // Modulo pipeline: one quotient bit per stage over the time stamp
  logic                div_vld_q  [TIME_W+1];
  lbb_mode_t           div_mode_q [TIME_W+1];
  logic [PERIOD_W-1:0] div_d_q    [TIME_W+1];
  logic [PERIOD_W-1:0] div_rem_q  [TIME_W+1];
  logic [TIME_W-1:0]   div_num_q  [TIME_W+1];
  logic                div_q_q    [TIME_W+1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      div_vld_q[0] <= 1'b0;
    end else begin
      div_vld_q[0] <= in_acc;
    end
  end

  always_ff @(posedge clk_i) begin
    div_mode_q[0] <= '{dim: dim_i, alarm: alarm_i, running: running_i};
    div_d_q[0]    <= div_in;
    div_rem_q[0]  <= '0;
    div_num_q[0]  <= now_ms_i;
    div_q_q[0]    <= 1'b0;
  end

  for (genvar gk = 1; gk <= TIME_W; gk++) begin : g_div
    logic [PERIOD_W-1:0] rem_d;
    logic                q_d;

    lbb_div_step u_step (
      .rem_i (div_rem_q[gk-1]),
      .bit_i (div_num_q[gk-1][TIME_W-1]),
      .div_i (div_d_q[gk-1]),
      .rem_o (rem_d),
      .q_o   (q_d)
    );

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        div_vld_q[gk] <= 1'b0;
      end else begin
        div_vld_q[gk] <= div_vld_q[gk-1];
      end
    end

    always_ff @(posedge clk_i) begin
      div_mode_q[gk] <= div_mode_q[gk-1];
      div_d_q[gk]    <= div_d_q[gk-1];
      div_rem_q[gk]  <= rem_d;
      div_num_q[gk]  <= {div_num_q[gk-1][TIME_W-2:0], 1'b0};
      div_q_q[gk]    <= q_d;
    end
  end

  // Scale the remainder by the curve depth and split it for the index division
  logic [XW-1:0] scaled;

  assign scaled = XW'(div_rem_q[TIME_W]) * XW'(CurveEntries);

  logic                ix_vld_q  [IdxW+1];
  lbb_mode_t           ix_mode_q [IdxW+1];
  logic [PERIOD_W-1:0] ix_d_q    [IdxW+1];
  logic                ix_par_q  [IdxW+1];
  logic [PERIOD_W-1:0] ix_rem_q  [IdxW+1];
  logic [IdxW-1:0]     ix_lo_q   [IdxW+1];
  logic [IdxW-1:0]     ix_quo_q  [IdxW+1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ix_vld_q[0] <= 1'b0;
    end else begin
      ix_vld_q[0] <= div_vld_q[TIME_W];
    end
  end

  always_ff @(posedge clk_i) begin
    ix_mode_q[0] <= div_mode_q[TIME_W];
    ix_d_q[0]    <= div_d_q[TIME_W];
    ix_par_q[0]  <= div_q_q[TIME_W];
    ix_rem_q[0]  <= scaled[XW-1:IdxW];
    ix_lo_q[0]   <= scaled[IdxW-1:0];
    ix_quo_q[0]  <= '0;
  end

  // Index pipeline: quotient of the scaled remainder by the period
  for (genvar gk = 1; gk <= IdxW; gk++) begin : g_idx
    logic [PERIOD_W-1:0] rem_d;
    logic                q_d;

    lbb_div_step u_step (
      .rem_i (ix_rem_q[gk-1]),
      .bit_i (ix_lo_q[gk-1][IdxW-1]),
      .div_i (ix_d_q[gk-1]),
      .rem_o (rem_d),
      .q_o   (q_d)
    );

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        ix_vld_q[gk] <= 1'b0;
      end else begin
        ix_vld_q[gk] <= ix_vld_q[gk-1];
      end
    end

    always_ff @(posedge clk_i) begin
      ix_mode_q[gk] <= ix_mode_q[gk-1];
      ix_d_q[gk]    <= ix_d_q[gk-1];
      ix_par_q[gk]  <= ix_par_q[gk-1];
      ix_rem_q[gk]  <= rem_d;
      ix_lo_q[gk]   <= {ix_lo_q[gk-1][IdxW-2:0], 1'b0};
      ix_quo_q[gk]  <= {ix_quo_q[gk-1][IdxW-2:0], q_d};
    end
  end

  // Curve lookup, flags ride alongside
  logic [LEVEL_W-1:0] curve;
  logic               rom_vld_q;
  lbb_mode_t          rom_mode_q;
  logic               rom_par_q;

  lbb_curve #(
    .CurveEntries (CurveEntries)
  ) u_curve (
    .clk_i  (clk_i),
    .addr_i (ix_quo_q[IdxW]),
    .data_o (curve)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rom_vld_q <= 1'b0;
    end else begin
      rom_vld_q <= ix_vld_q[IdxW];
    end
  end

  always_ff @(posedge clk_i) begin
    rom_mode_q <= ix_mode_q[IdxW];
    rom_par_q  <= ix_par_q[IdxW];
  end

  // Scale the curve into the breathing range
  logic [LEVEL_W-1:0]   span;
  logic [2*LEVEL_W-1:0] prod;
  logic [LEVEL_W-1:0]   breath;

  assign span   = (breath_max_q > breath_min_q) ? (breath_max_q - breath_min_q) : '0;
  assign prod   = curve * span;
  assign breath = breath_min_q + prod[2*LEVEL_W-1:LEVEL_W];

  // Output register: select by mode
  logic               out_vld_q;
  logic [LEVEL_W-1:0] level_d, red_d, green_d, blue_d;
  logic [LEVEL_W-1:0] level_q, red_q, green_q, blue_q;

  always_comb begin
    if (rom_mode_q.dim) begin
      level_d = '0;
      red_d   = '0;
      green_d = '0;
      blue_d  = '0;
    end else if (rom_mode_q.alarm) begin
      level_d = rom_par_q ? '0 : alarm_level_q;
      red_d   = COL_ALARM_R;
      green_d = COL_ALARM_G;
      blue_d  = COL_ALARM_B;
    end else if (rom_mode_q.running) begin
      level_d = breath;
      red_d   = COL_RUN_R;
      green_d = COL_RUN_G;
      blue_d  = COL_RUN_B;
    end else begin
      level_d = breath;
      red_d   = COL_IDLE_R;
      green_d = COL_IDLE_G;
      blue_d  = COL_IDLE_B;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else begin
      out_vld_q <= rom_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    level_q <= level_d;
    red_q   <= red_d;
    green_q <= green_d;
    blue_q  <= blue_d;
  end

  assign out_valid_o = out_vld_q;
  assign level_o     = level_q;
  assign red_o       = red_q;
  assign green_o     = green_q;
  assign blue_o      = blue_q;

endmodule

@@ dv/led_breathing_blink_brightness_tb.sv @@
`timescale 1ns / 1ps

module led_breathing_blink_brightness_tb;
  import lbb_pkg::*;

  localparam int unsigned CURVE_N      = CURVE_ENTRIES_DEF;
  localparam int unsigned PIPE_LATENCY = 43;
  localparam int unsigned CYCLE_LIMIT  = 400000;
  localparam int unsigned RAND_PHASES  = 7;
  localparam int unsigned PHASE_ITEMS  = 250;
  localparam longint unsigned PI_Q30   = 64'd3373259426;

  typedef struct packed {
    logic [LEVEL_W-1:0] level;
    logic [LEVEL_W-1:0] red;
    logic [LEVEL_W-1:0] green;
    logic [LEVEL_W-1:0] blue;
  } strip_colour_t;

  logic                  clk_i       = 1'b0;
  logic                  rst_ni      = 1'b0;
  logic                  start       = 1'b0;
  logic                  busy;
  logic [TIME_W-1:0]     now_ms_i    = '0;
  logic                  dim_i       = 1'b0;
  logic                  alarm_i     = 1'b0;
  logic                  running_i   = 1'b0;
  logic                  out_valid_o;
  logic [LEVEL_W-1:0]    level_o;
  logic [LEVEL_W-1:0]    red_o;
  logic [LEVEL_W-1:0]    green_o;
  logic [LEVEL_W-1:0]    blue_o;
  logic                  cfg_valid_i = 1'b0;
  logic                  cfg_ready_o;
  logic [CFG_IDX_W-1:0]  cfg_index_i = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i  = '0;

  // Register shadow used for prediction
  logic [LEVEL_W-1:0]  cur_breath_min  = RST_BREATH_MIN;
  logic [LEVEL_W-1:0]  cur_breath_max  = RST_BREATH_MAX;
  logic [LEVEL_W-1:0]  cur_alarm_level = RST_ALARM_LEVEL;
  logic [PERIOD_W-1:0] cur_blink_half  = RST_BLINK_HALF;
  logic [PERIOD_W-1:0] cur_run_period  = RST_RUN_PERIOD;
  logic [PERIOD_W-1:0] cur_idle_period = RST_IDLE_PERIOD;

  logic [LEVEL_W-1:0] curve_q8 [CURVE_N];
  strip_colour_t      expected_colours [$];

  int unsigned idle_pct       = 0;
  int unsigned items_sent     = 0;
  int unsigned colours_seen   = 0;
  int unsigned settings_count = 0;
  int unsigned mismatches     = 0;
  int unsigned fault_count    = 0;
  int unsigned cycle_count    = 0;

  led_breathing_blink_brightness dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start      (start),
    .busy       (busy),
    .now_ms_i   (now_ms_i),
    .dim_i      (dim_i),
    .alarm_i    (alarm_i),
    .running_i  (running_i),
    .out_valid_o(out_valid_o),
    .level_o    (level_o),
    .red_o      (red_o),
    .green_o    (green_o),
    .blue_o     (blue_o),
    .cfg_valid_i(cfg_valid_i),
    .cfg_ready_o(cfg_ready_o),
    .cfg_index_i(cfg_index_i),
    .cfg_data_i (cfg_data_i)
  );

  always #6 clk_i = ~clk_i;

  // Abort on a hung run
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles, %0d colours outstanding", cycle_count,
               expected_colours.size());
      $display("Test completed with failures");
      $finish;
    end
  end

  // Q30 sine for angles up to pi/2, truncated Taylor series
  function automatic longint unsigned sine_q30(longint unsigned angle);
    longint unsigned term;
    longint unsigned pos_sum;
    longint unsigned neg_sum;
    longint unsigned k;
    term    = angle;
    pos_sum = 0;
    neg_sum = 0;
    for (k = 0; k < 12; k++) begin
      if (k[0] == 1'b0) pos_sum += term;
      else neg_sum += term;
      term = (term * angle) >> 30;
      term = (term * angle) >> 30;
      term = term / ((2 * k + 2) * (2 * k + 3));
    end
    return (pos_sum > neg_sum) ? (pos_sum - neg_sum) : 64'd0;
  endfunction

  // Fill the raised-cosine table in Q0.8
  task automatic build_curve();
    longint unsigned j;
    longint unsigned s;
    longint unsigned t;
    for (int unsigned i = 0; i < CURVE_N; i++) begin
      j = (2 * i <= CURVE_N) ? i : CURVE_N - i;
      s = sine_q30((PI_Q30 * j) / CURVE_N);
      if (s > (64'd1 << 30)) s = 64'd1 << 30;
      t = (s * s + (64'd1 << 51)) >> 52;
      curve_q8[i] = (t > 255) ? 8'd255 : t[7:0];
    end
  endtask

  function automatic strip_colour_t predict_colour(logic [TIME_W-1:0] now, logic dim_f,
                                                   logic alarm_f, logic running_f);
    strip_colour_t   c;
    longint unsigned stamp;
    longint unsigned half;
    longint unsigned period;
    longint unsigned idx;
    longint unsigned span;
    c     = '0;
    stamp = now;
    if (dim_f) begin
      c = '0;
    end else if (alarm_f) begin
      half    = (cur_blink_half == 0) ? 64'd1 : cur_blink_half;
      c.level = (((stamp / half) & 64'd1) == 0) ? cur_alarm_level : '0;
      c.red   = COL_ALARM_R;
      c.green = COL_ALARM_G;
      c.blue  = COL_ALARM_B;
    end else begin
      period  = running_f ? cur_run_period : cur_idle_period;
      if (period == 0) period = 1;
      idx     = ((stamp % period) * CURVE_N) / period;
      span    = (cur_breath_max > cur_breath_min) ? cur_breath_max - cur_breath_min : 0;
      c.level = cur_breath_min + ((curve_q8[idx] * span) >> 8);
      if (running_f) begin
        c.red = COL_RUN_R; c.green = COL_RUN_G; c.blue = COL_RUN_B;
      end else begin
        c.red = COL_IDLE_R; c.green = COL_IDLE_G; c.blue = COL_IDLE_B;
      end
    end
    return c;
  endfunction

  function automatic void check_field(string fname, logic [7:0] exp_v, logic [7:0] act_v);
    if (exp_v !== act_v) begin
      mismatches++;
      fault_count++;
      if (mismatches <= 10)
        $display("Mismatch on %s at colour %0d: expected %0d, got %0d", fname,
                 colours_seen, exp_v, act_v);
    end
  endfunction

  // Compare each strobed colour with the oldest prediction
  always @(posedge clk_i) begin
    strip_colour_t exp_c;
    if (rst_ni && out_valid_o === 1'b1) begin
      if (expected_colours.size() == 0) begin
        fault_count++;
        mismatches++;
        if (mismatches <= 10) $display("Unexpected colour strobe, none predicted");
      end else begin
        exp_c = expected_colours.pop_front();
        check_field("level", exp_c.level, level_o);
        check_field("red", exp_c.red, red_o);
        check_field("green", exp_c.green, green_o);
        check_field("blue", exp_c.blue, blue_o);
      end
      colours_seen++;
    end
  end

  // Send one time stamp beat, start left high for a back-to-back follow-on
  task automatic send_item(logic [TIME_W-1:0] now, logic dim_f, logic alarm_f,
                           logic running_f);
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk_i);
    end
    start     <= 1'b1;
    now_ms_i  <= now;
    dim_i     <= dim_f;
    alarm_i   <= alarm_f;
    running_i <= running_f;
    do @(posedge clk_i); while (busy !== 1'b0);
    expected_colours.push_back(predict_colour(now, dim_f, alarm_f, running_f));
    items_sent++;
  endtask

  // Drop start and hold until every prediction has been matched
  task automatic drain_results();
    start <= 1'b0;
    while (expected_colours.size() != 0) @(posedge clk_i);
    @(posedge clk_i);
  endtask

  // Register write beat, valid left high for the next write
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (cfg_ready_o !== 1'b1);
    case (idx)
      REG_BREATH_MIN:  cur_breath_min  = data[7:0];
      REG_BREATH_MAX:  cur_breath_max  = data[7:0];
      REG_ALARM_LEVEL: cur_alarm_level = data[7:0];
      REG_BLINK_HALF:  cur_blink_half  = data;
      REG_RUN_PERIOD:  cur_run_period  = data;
      REG_IDLE_PERIOD: cur_idle_period = data;
      default: ;
    endcase
  endtask

  // Program the full set; upper byte of 8-bit registers carries junk
  task automatic program_regs(logic [7:0] bmin, logic [7:0] bmax, logic [7:0] alvl,
                              logic [15:0] blink, logic [15:0] runp, logic [15:0] idlep);
    logic [CFG_IDX_W-1:0] junk_idx;
    junk_idx = $urandom_range(1) ? 3'd6 : 3'd7;
    write_reg(REG_BREATH_MIN, {8'($urandom), bmin});
    write_reg(REG_BREATH_MAX, {8'($urandom), bmax});
    write_reg(REG_ALARM_LEVEL, {8'($urandom), alvl});
    write_reg(REG_BLINK_HALF, blink);
    write_reg(REG_RUN_PERIOD, runp);
    write_reg(REG_IDLE_PERIOD, idlep);
    write_reg(junk_idx, 16'($urandom));
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
    settings_count++;
  endtask

  function automatic logic [15:0] pick_period();
    case ($urandom_range(3))
      0:       return 16'($urandom_range(3));
      1:       return 16'($urandom_range(600, 1));
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [TIME_W-1:0] pick_time();
    case ($urandom_range(4))
      0:       return TIME_W'($urandom_range(5000));
      1:       return 32'hFFFF_FFFF - $urandom_range(5000);
      2:       return cur_run_period * $urandom_range(60000) + $urandom_range(2) - 1;
      3:       return cur_idle_period * $urandom_range(60000) + $urandom_range(2) - 1;
      default: return TIME_W'($urandom);
    endcase
  endfunction

  // Reset values: dark, alarm halves, both breathing periods
  task automatic test_default_registers();
    idle_pct = 0;
    send_item(32'd0, 1'b1, 1'b1, 1'b1);
    send_item(32'hFFFF_FFFF, 1'b1, 1'b0, 1'b0);
    send_item(32'd0, 1'b0, 1'b1, 1'b0);
    send_item(32'd399, 1'b0, 1'b1, 1'b1);
    send_item(32'd400, 1'b0, 1'b1, 1'b0);
    send_item(32'hFFFF_FFFF, 1'b0, 1'b1, 1'b0);
    send_item(32'd0, 1'b0, 1'b0, 1'b1);
    send_item(32'd1000, 1'b0, 1'b0, 1'b1);
    send_item(32'd1999, 1'b0, 1'b0, 1'b1);
    send_item(32'd1500, 1'b0, 1'b0, 1'b0);
    send_item(32'd2999, 1'b0, 1'b0, 1'b0);
    send_item(32'hFFFF_FFFF, 1'b0, 1'b0, 1'b0);
    drain_results();
  endtask

  // Full span with shortest and longest periods, then inverted bounds and zero periods
  task automatic test_register_extremes();
    idle_pct = 0;
    program_regs(8'd0, 8'd255, 8'd255, 16'd1, 16'd1, 16'd65535);
    send_item(32'd0, 1'b0, 1'b1, 1'b1);
    send_item(32'd1, 1'b0, 1'b1, 1'b0);
    send_item(32'd12345, 1'b0, 1'b0, 1'b1);
    send_item(32'd32767, 1'b0, 1'b0, 1'b0);
    send_item(32'd32768, 1'b0, 1'b0, 1'b0);
    send_item(32'd65534, 1'b0, 1'b0, 1'b0);
    send_item(32'd65535, 1'b1, 1'b0, 1'b0);
    drain_results();
    program_regs(8'd255, 8'd0, 8'd0, 16'd0, 16'd0, 16'd0);
    send_item(32'd3, 1'b0, 1'b1, 1'b0);
    send_item(32'd7, 1'b0, 1'b0, 1'b1);
    send_item(32'hFFFF_FFFF, 1'b0, 1'b0, 1'b0);
    drain_results();
  endtask

  // Random time stamps and flags over several register settings and pacings
  task automatic test_random_traffic();
    int unsigned pacing [3];
    pacing = '{0, 86, 9};
    for (int unsigned ph = 0; ph < RAND_PHASES; ph++) begin
      case (ph)
        0: program_regs(RST_BREATH_MIN, RST_BREATH_MAX, RST_ALARM_LEVEL, RST_BLINK_HALF,
                        RST_RUN_PERIOD, RST_IDLE_PERIOD);
        1: program_regs(8'd0, 8'd255, 8'd255, 16'd65535, 16'd65535, 16'd1);
        2: program_regs(8'd200, 8'd100, 8'd1, 16'd0, 16'd0, 16'd2);
        default: program_regs(8'($urandom), 8'($urandom), 8'($urandom), pick_period(),
                              pick_period(), pick_period());
      endcase
      idle_pct = pacing[ph % 3];
      repeat (PHASE_ITEMS)
        send_item(pick_time(), $urandom_range(3) == 0, $urandom_range(2) == 0,
                  1'($urandom));
      drain_results();
    end
  endtask

  initial begin
    build_curve();
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_default_registers();
    test_register_extremes();
    test_random_traffic();

    repeat (PIPE_LATENCY + 8) @(posedge clk_i);
    if (expected_colours.size() != 0) begin
      fault_count++;
      $display("%0d predicted colours never arrived", expected_colours.size());
    end
    $display("Sent %0d time stamps under %0d register settings, checked %0d colours",
             items_sent, settings_count, colours_seen);
    $display("Paced back to back, sparse and lightly gapped; %0d field mismatches",
             mismatches);
    if (fault_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
